// ===== rtl/core/mbrtu_pkg.sv =====
// Package for the Modbus RTU slave frame handler: widths, codes, CRC step function
// and the command record passed from the frame front end to the reply engine.
// No dependencies.
package mbrtu_pkg;

   localparam int RegCountDefault    = 128;
   localparam int MaxReadRegsDefault = 16;
   localparam int CmdQueueDepth      = 2;

   localparam logic [7:0]  FnReadHolding = 8'd3;
   localparam logic [7:0]  FnReadInput   = 8'd4;
   localparam logic [7:0]  FnWriteSingle = 8'd6;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;

   localparam logic [1:0] CsrDeviceAddress   = 2'd0;
   localparam logic [1:0] CsrFamilyCode      = 2'd1;
   localparam logic [1:0] CsrFirmwareVersion = 2'd2;

   typedef struct packed {
      logic [7:0]  fn;
      logic [15:0] addr;
      logic [15:0] val;
   } reply_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HEAD, ST_FETCH, ST_DATA, ST_CRC_LO, ST_CRC_HI
   } eng_state_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/modbus_rtu_slave_frame_handler_unit.sv =====
// Modbus RTU slave frame handler, top level: front end, command queue, reply engine.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_cmd_fifo, mbrtu_engine.
// Received bytes and frame-end markers are taken one per cycle while full is low;
// full rises only when the reply engine holds one accepted request and a second one
// waits behind it. Each register read in a reply needs a fetch step first, and replies
// are held back while pop is held low, paced by the single-port holding
// register memory and the one-entry output register.
module modbus_rtu_slave_frame_handler_unit import mbrtu_pkg::*; #(
   parameter int REG_COUNT     = RegCountDefault,
   parameter int MAX_READ_REGS = MaxReadRegsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic        rsp_write_done,
   output logic [6:0]  rsp_write_addr,
   output logic [15:0] rsp_write_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic [7:0]    dev_ff;
   logic [15:0]   fam_ff, ver_ff;
   logic          accept, cmd_valid, q_empty, q_pop;
   reply_cmd_type cmd_in, cmd_out;

   assign accept = req_push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= 8'd3;
         fam_ff <= 16'd5;
         ver_ff <= 16'd15;
      end else if (csr_we) begin
         case (csr_index)
            CsrDeviceAddress:   dev_ff <= csr_wdata[7:0];
            CsrFamilyCode:      fam_ff <= csr_wdata;
            CsrFirmwareVersion: ver_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mbrtu_front #(.REG_COUNT(REG_COUNT), .MAX_READ_REGS(MAX_READ_REGS)) u_front (
      .clock, .reset, .in_valid(accept), .in_op(req_op), .in_byte(req_rx_byte),
      .dev_addr(dev_ff), .cmd_valid, .cmd(cmd_in)
   );

   mbrtu_cmd_fifo u_fifo (
      .clock, .reset, .push(cmd_valid), .push_data(cmd_in), .full,
      .pop(q_pop), .empty(q_empty), .pop_data(cmd_out)
   );

   mbrtu_engine #(.REG_COUNT(REG_COUNT)) u_engine (
      .clock, .reset, .cmd_empty(q_empty), .cmd(cmd_out), .cmd_pop(q_pop),
      .dev_addr(dev_ff), .family_code(fam_ff), .fw_version(ver_ff),
      .out_empty(empty), .out_pop(pop), .tx_byte(rsp_tx_byte), .tx_last(rsp_tx_last),
      .write_done(rsp_write_done), .write_addr(rsp_write_addr),
      .write_data(rsp_write_data)
   );
endmodule

// ===== rtl/core/mbrtu_front.sv =====
// Frame front end: stores the first eight bytes, runs the receive CRC and checks
// the frame on frame end. Depends on mbrtu_pkg.
module mbrtu_front import mbrtu_pkg::*; #(
   parameter int REG_COUNT     = RegCountDefault,
   parameter int MAX_READ_REGS = MaxReadRegsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          in_op,
   input  logic [7:0]    in_byte,
   input  logic [7:0]    dev_addr,
   output logic          cmd_valid,
   output reply_cmd_type cmd
);
   logic [7:0]  bytes_ff [8];
   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        ok;
   logic [15:0] addr, val;
   logic [16:0] span;

   assign addr = {bytes_ff[2], bytes_ff[3]};
   assign val  = {bytes_ff[4], bytes_ff[5]};
   assign span = {1'b0, addr} + {1'b0, val};

   always_comb begin
      ok = 1'b0;
      if (count_ff[3] && bytes_ff[0] == dev_addr && crc_ff == 16'h0000) begin
         if (bytes_ff[1] == FnReadHolding || bytes_ff[1] == FnReadInput) begin
            ok = val != 16'd0 && val <= 16'(MAX_READ_REGS) && span <= 17'(REG_COUNT);
         end else if (bytes_ff[1] == FnWriteSingle) begin
            ok = {1'b0, addr} < 17'(REG_COUNT);
         end
      end
   end

   assign cmd_valid = in_valid && in_op && ok;
   assign cmd = '{fn: bytes_ff[1], addr: addr, val: val};

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (in_valid) begin
         if (in_op) begin
            count_in = '0;
            crc_in   = CrcInit;
         end else if (!count_ff[3]) begin
            count_in = count_ff + 4'd1;
            crc_in   = crc_byte(crc_ff, in_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CrcInit;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
      if (in_valid && !in_op && !count_ff[3]) begin
         bytes_ff[count_ff[2:0]] <= in_byte;
      end
   end
endmodule

// ===== rtl/core/mbrtu_cmd_fifo.sv =====
// Short command queue between front end and reply engine. Depends on mbrtu_pkg.
module mbrtu_cmd_fifo import mbrtu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  reply_cmd_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output reply_cmd_type pop_data
);
   reply_cmd_type slot_ff [CmdQueueDepth];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'(CmdQueueDepth);
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wp_ff] <= push_data;
   end
endmodule

// ===== rtl/core/mbrtu_engine.sv =====
// Reply engine: owns the holding register memory, performs writes and streams reply
// bytes with CRC into a one-entry output register. Depends on mbrtu_pkg.
module mbrtu_engine import mbrtu_pkg::*; #(
   parameter int REG_COUNT = RegCountDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_empty,
   input  reply_cmd_type cmd,
   output logic          cmd_pop,
   input  logic [7:0]    dev_addr,
   input  logic [15:0]   family_code,
   input  logic [15:0]   fw_version,
   output logic          out_empty,
   input  logic          out_pop,
   output logic [7:0]    tx_byte,
   output logic          tx_last,
   output logic          write_done,
   output logic [6:0]    write_addr,
   output logic [15:0]   write_data
);
   localparam int AW = $clog2(REG_COUNT);

   logic [15:0] mem [REG_COUNT];
   logic [15:0] rd_ff;
   logic [REG_COUNT-1:0] vld_ff;
   logic        rd_vld_ff;

   eng_state_type st_ff, st_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [4:0]  left_ff, left_in;
   logic [15:0] crc_ff, crc_in;
   logic        ov_ff;
   logic [7:0]  ob_ff;
   logic        ol_ff, ow_ff;
   logic [6:0]  oa_ff;
   logic [15:0] od_ff;

   logic        slot_free, emit, emit_last, emit_w, do_write, do_read;
   logic [7:0]  emit_byte;
   logic [15:0] word;

   assign slot_free = !ov_ff || out_pop;
   assign do_write  = st_ff == ST_IDLE && !cmd_empty && cmd.fn == FnWriteSingle;

   always_comb begin
      word = 16'h0000;
      if (cmd.fn == FnReadHolding) begin
         word = rd_vld_ff ? rd_ff : 16'h0000;
      end else if (ptr_ff == 16'd0) begin
         word = {8'h00, dev_addr};
      end else if (ptr_ff == 16'd1) begin
         word = family_code;
      end else if (ptr_ff == 16'd2) begin
         word = fw_version;
      end
   end

   // next state
   always_comb begin
      st_in   = st_ff;
      idx_in  = idx_ff;
      ptr_in  = ptr_ff;
      left_in = left_ff;
      crc_in  = crc_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               st_in  = ST_HEAD;
               idx_in = '0;
               ptr_in = cmd.addr;
               left_in = cmd.val[4:0];
               crc_in = CrcInit;
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               crc_in = crc_byte(crc_ff, emit_byte);
               idx_in = idx_ff + 3'd1;
               if (cmd.fn == FnWriteSingle) begin
                  if (idx_ff == 3'd5) st_in = ST_CRC_LO;
               end else if (idx_ff == 3'd2) begin
                  st_in  = ST_FETCH;
                  idx_in = '0;
               end
            end
         end
         ST_FETCH: st_in = ST_DATA;
         ST_DATA: begin
            if (slot_free) begin
               crc_in = crc_byte(crc_ff, emit_byte);
               idx_in = idx_ff + 3'd1;
               if (idx_ff[0]) begin
                  ptr_in  = ptr_ff + 16'd1;
                  left_in = left_ff - 5'd1;
                  idx_in  = '0;
                  st_in   = (left_ff == 5'd1) ? ST_CRC_LO : ST_FETCH;
               end
            end
         end
         ST_CRC_LO: if (slot_free) st_in = ST_CRC_HI;
         ST_CRC_HI: if (slot_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      emit_byte = 8'h00;
      emit_last = 1'b0;
      emit_w = 1'b0;
      cmd_pop = 1'b0;
      do_read = 1'b0;
      case (st_ff)
         ST_HEAD: begin
            emit = slot_free;
            case (idx_ff)
               3'd0: emit_byte = dev_addr;
               3'd1: emit_byte = cmd.fn;
               3'd2: emit_byte = (cmd.fn == FnWriteSingle) ? cmd.addr[7:0]
                                                         : {cmd.val[6:0], 1'b0};
               3'd3: emit_byte = cmd.addr[7:0];
               3'd4: emit_byte = cmd.val[15:8];
               3'd5: emit_byte = cmd.val[7:0];
               default: emit_byte = 8'h00;
            endcase
            if (cmd.fn == FnWriteSingle && idx_ff == 3'd2) emit_byte = cmd.addr[15:8];
            emit_w = cmd.fn == FnWriteSingle && idx_ff == 3'd0;
         end
         ST_FETCH: do_read = 1'b1;
         ST_DATA: begin
            emit = slot_free;
            emit_byte = idx_ff[0] ? word[7:0] : word[15:8];
         end
         ST_CRC_LO: begin
            emit = slot_free;
            emit_byte = crc_ff[7:0];
         end
         ST_CRC_HI: begin
            emit = slot_free;
            emit_byte = crc_ff[15:8];
            emit_last = 1'b1;
            cmd_pop = slot_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         ov_ff  <= 1'b0;
         vld_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (emit) ov_ff <= 1'b1;
         else if (out_pop) ov_ff <= 1'b0;
         if (do_write) vld_ff[cmd.addr[AW-1:0]] <= 1'b1;
      end
      idx_ff  <= idx_in;
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      crc_ff  <= crc_in;
      if (emit) begin
         ob_ff <= emit_byte;
         ol_ff <= emit_last;
         ow_ff <= emit_w;
         oa_ff <= emit_w ? cmd.addr[6:0] : 7'd0;
         od_ff <= emit_w ? cmd.val : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[cmd.addr[AW-1:0]] <= cmd.val;
      if (do_read) begin
         rd_ff     <= mem[ptr_ff[AW-1:0]];
         rd_vld_ff <= vld_ff[ptr_ff[AW-1:0]];
      end
   end

   assign out_empty  = !ov_ff;
   assign tx_byte    = ob_ff;
   assign tx_last    = ol_ff;
   assign write_done = ow_ff;
   assign write_addr = oa_ff;
   assign write_data = od_ff;
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the Modbus RTU slave frame handler: builds request frames, predicts reply
// bytes with its own CRC and register model and checks each reply transfer in order.
// Depends on mbrtu_pkg and modbus_rtu_slave_frame_handler_unit.

class reply_board;
   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        write_done;
      logic [6:0]  write_addr;
      logic [15:0] write_data;
   } reply_type;

   reply_type pending[$];
   int        errors;

   logic [7:0]  dev_addr;
   logic [15:0] family;
   logic [15:0] fw_version;
   logic [7:0]  frame[8];
   int          count;
   logic [15:0] crc_run;
   logic [15:0] hold_regs[128];

   function new();
      errors = 0;
      dev_addr = 3;
      family = 5;
      fw_version = 15;
      foreach (hold_regs[i]) hold_regs[i] = 16'h0;
      clear();
   endfunction

   function void clear();
      foreach (frame[i]) frame[i] = 8'h00;
      count = 0;
      crc_run = mbrtu_pkg::CrcInit;
   endfunction

   static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
         mbrtu_pkg::CsrDeviceAddress:   dev_addr = v[7:0];
         mbrtu_pkg::CsrFamilyCode:      family = v;
         mbrtu_pkg::CsrFirmwareVersion: fw_version = v;
         default: ;
      endcase
   endfunction

   function logic [15:0] input_reg(int idx);
      if (idx == 0) return {8'h00, dev_addr};
      if (idx == 1) return family;
      if (idx == 2) return fw_version;
      return 16'h0;
   endfunction

   // Note one accepted request item and queue the reply bytes it causes.
   function void note_request(logic op, logic [7:0] b);
      logic [7:0]  reply[$];
      logic [7:0]  fn;
      logic [15:0] addr, val, crc;
      logic        wrote;
      reply_type   r;
      if (!op) begin
         if (count < 8) begin
            frame[count] = b;
            crc_run = crc_step(crc_run, b);
            count++;
         end
         return;
      end
      fn = frame[1];
      addr = {frame[2], frame[3]};
      val = {frame[4], frame[5]};
      wrote = 1'b0;
      if (count >= 8 && frame[0] == dev_addr && crc_run == 16'h0) begin
         if (fn == mbrtu_pkg::FnReadHolding || fn == mbrtu_pkg::FnReadInput) begin
            if (val >= 1 && val <= 16 && int'(addr) + int'(val) <= 128) begin
               reply.push_back(dev_addr);
               reply.push_back(fn);
               reply.push_back(val[7:0] << 1);
               for (int i = 0; i < val; i++) begin
                  logic [15:0] w;
                  w = (fn == mbrtu_pkg::FnReadHolding) ? hold_regs[addr + i]
                                                       : input_reg(addr + i);
                  reply.push_back(w[15:8]);
                  reply.push_back(w[7:0]);
               end
            end
         end else if (fn == mbrtu_pkg::FnWriteSingle && addr < 128) begin
            hold_regs[addr] = val;
            wrote = 1'b1;
            reply.push_back(dev_addr);
            for (int k = 1; k < 6; k++) reply.push_back(frame[k]);
         end
      end
      if (reply.size() > 0) begin
         crc = mbrtu_pkg::CrcInit;
         foreach (reply[k]) crc = crc_step(crc, reply[k]);
         reply.push_back(crc[7:0]);
         reply.push_back(crc[15:8]);
         foreach (reply[k]) begin
            r.tx_byte = reply[k];
            r.tx_last = (k == reply.size() - 1);
            r.write_done = wrote && k == 0;
            r.write_addr = r.write_done ? addr[6:0] : 7'h0;
            r.write_data = r.write_done ? val : 16'h0;
            pending.push_back(r);
         end
      end
      clear();
   endfunction

   function void check_reply(reply_type got);
      reply_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected reply byte %h", $time, got.tx_byte);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
         $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
         errors++;
      end
      if (got.tx_last !== want.tx_last) begin
         $display("%0t: tx_last expected %b actual %b", $time, want.tx_last, got.tx_last);
         errors++;
      end
      if (got.write_done !== want.write_done) begin
         $display("%0t: write_done expected %b actual %b", $time, want.write_done,
                  got.write_done);
         errors++;
      end
      if (got.write_addr !== want.write_addr) begin
         $display("%0t: write_addr expected %h actual %h", $time, want.write_addr,
                  got.write_addr);
         errors++;
      end
      if (got.write_data !== want.write_data) begin
         $display("%0t: write_data expected %h actual %h", $time, want.write_data,
                  got.write_data);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import mbrtu_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        full;
   logic        req_op;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_write_done;
   logic [6:0]  rsp_write_addr;
   logic [15:0] rsp_write_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   reply_board board;
   int  cycles = 0;
   bit  no_idle;

   modbus_rtu_slave_frame_handler_unit u_top (
      .clock(clock), .reset(reset), .req_push(req_push), .full(full), .req_op(req_op),
      .req_rx_byte(req_rx_byte), .empty(empty), .pop(pop), .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last), .rsp_write_done(rsp_write_done),
      .rsp_write_addr(rsp_write_addr), .rsp_write_data(rsp_write_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 29);
   endfunction

   // Hold each item until a transfer takes place, idling at random beforehand.
   task automatic send_item(logic op, logic [7:0] b);
      while (idle_now()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_request(op, b);
   endtask

   task automatic send_frame(logic [7:0] bytes[$]);
      foreach (bytes[i]) send_item(1'b0, bytes[i]);
      send_item(1'b1, 8'($urandom));
   endtask

   function automatic void build(ref logic [7:0] f[$], input logic [7:0] a, fn,
                                 input logic [15:0] addr, val, input bit bad_crc);
      logic [15:0] crc;
      f = {a, fn, addr[15:8], addr[7:0], val[15:8], val[7:0]};
      crc = CrcInit;
      foreach (f[i]) crc = crc_byte(crc, f[i]);
      if (bad_crc) crc ^= 16'h1 << $urandom_range(15);
      f.push_back(crc[7:0]);
      f.push_back(crc[15:8]);
   endfunction

   task automatic frame(logic [7:0] fn, logic [15:0] addr, val);
      logic [7:0] f[$];
      build(f, board.dev_addr, fn, addr, val, 1'b0);
      send_frame(f);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_frame();
      logic [7:0]  f[$];
      logic [7:0]  fn;
      logic [15:0] addr, val;
      int kind;
      kind = $urandom_range(99);
      fn = ($urandom_range(2) == 0) ? FnReadHolding :
           ($urandom_range(1) == 0) ? FnReadInput : FnWriteSingle;
      if (fn == FnWriteSingle) begin
         addr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(127));
         val = 16'($urandom);
      end else begin
         val = ($urandom_range(9) == 0) ? 16'($urandom_range(20))
                                        : 16'($urandom_range(1, 16));
         addr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(128 - 1));
         if ($urandom_range(3) == 0 && val <= 128) addr = 16'd128 - val;
      end
      if (kind < 75) begin
         build(f, board.dev_addr, fn, addr, val, 1'b0);
      end else if (kind < 82) begin
         build(f, board.dev_addr, fn, addr, val, 1'b1);
      end else if (kind < 87) begin
         build(f, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end else if (kind < 93) begin
         build(f, board.dev_addr, fn, addr, val, 1'b0);
         repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 7)) f.push_back(8'($urandom));
      end
      send_frame(f);
   endtask

   // Result side: pop at random and check every transfer.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            board.check_reply({rsp_tx_byte, rsp_tx_last, rsp_write_done,
                               rsp_write_addr, rsp_write_data});
         pop <= !idle_now();
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("** modbus_rtu_slave_frame_handler_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [7:0] f[$];
      board = new();
      no_idle = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_op = 1'b0;
      req_rx_byte = 8'h00;
      csr_we = 1'b0;
      csr_index = CsrDeviceAddress;
      csr_wdata = 16'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, every function, edges of the ranges.
      frame(FnReadInput, 16'd0, 16'd4);
      frame(FnWriteSingle, 16'd127, 16'hFFFF);
      frame(FnWriteSingle, 16'd0, 16'h0001);
      frame(FnReadHolding, 16'd112, 16'd16);
      frame(FnReadHolding, 16'd0, 16'd1);
      frame(FnReadHolding, 16'd113, 16'd16);
      frame(FnReadHolding, 16'd0, 16'd0);
      frame(FnReadInput, 16'd0, 16'd17);
      frame(FnWriteSingle, 16'd128, 16'h1234);
      frame(FnWriteSingle, 16'hFF80, 16'h5678);
      build(f, board.dev_addr, FnWriteSingle, 16'd5, 16'hA5A5, 1'b0);
      f.push_back(8'hFF);
      f.push_back(8'h00);
      send_frame(f);
      build(f, board.dev_addr, FnWriteSingle, 16'd5, 16'hA5A5, 1'b1);
      send_frame(f);
      build(f, board.dev_addr, 8'd5, 16'd5, 16'h1, 1'b0);
      send_frame(f);
      build(f, 8'd0, FnReadHolding, 16'd5, 16'h1, 1'b0);
      send_frame(f);
      f = {board.dev_addr, FnReadHolding, 8'h00};
      send_frame(f);
      send_item(1'b1, 8'hFF);
      settle();

      write_csr(CsrDeviceAddress, 16'd247);
      write_csr(CsrFamilyCode, 16'hFFFF);
      write_csr(CsrFirmwareVersion, 16'h0000);
      frame(FnReadInput, 16'd0, 16'd3);
      frame(FnWriteSingle, 16'd64, 16'h8000);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CsrDeviceAddress, (phase == 0) ? 16'd1 : 16'($urandom_range(1, 247)));
         write_csr(CsrFamilyCode, 16'($urandom));
         write_csr(CsrFirmwareVersion, (phase == 0) ? 16'hFFFF : 16'($urandom));
         no_idle = (phase == 2);
         frame(FnReadInput, 16'd0, 16'd3);
         for (int n = 0; n < 5; n++) random_frame();
         no_idle = 1'b0;
         settle();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("** modbus_rtu_slave_frame_handler_unit: PASSED **");
      else
         $display("** modbus_rtu_slave_frame_handler_unit: FAILED **");
      $finish;
   end
endmodule
